[hw/rtl/tts_pkg.sv]
// shared constants, codes and types of the tick task scheduler table
package tts_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_OUT       = 8;
   localparam int HIT_W         = $clog2(MAX_OUT);

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 3;
   localparam int TASK_W   = 16;
   localparam int TIME_W   = 32;
   localparam int PEND_W   = 8;

   localparam logic [OP_W-1:0] OP_UPDATE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;
   localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RUN   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [PEND_W-1:0] pending;
   } slot_row_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } tts_cmd_type;

   typedef struct packed {
      logic emit;
      logic finish;
      logic out_free;
   } tts_sts_type;

endpackage

[hw/rtl/tts_ctrl.sv]
// sequencing state machine of the tick task scheduler table
module tts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tts_pkg::tts_sts_type sts,
   output tts_pkg::tts_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   assign req_ready = req_ready_ff;

   always_comb begin
      cmd.accept   = req_valid && req_ready_ff;
      // a step that produces a result waits for room in the output register
      cmd.commit   = (state_ff == S_EXEC) && !(sts.emit && !sts.out_free);
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in     = S_READ;
               req_ready_in = 1'b0;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) begin
               if (sts.finish) begin
                  state_in     = S_IDLE;
                  req_ready_in = 1'b1;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

endmodule

[hw/rtl/tts_dpath.sv]
// slot table storage, scan pointer and result register of the scheduler table
module tts_dpath #(
   parameter int SLOTS = tts_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tts_pkg::tts_cmd_type              cmd,
   output tts_pkg::tts_sts_type              sts,
   input  logic [tts_pkg::OP_W-1:0]          req_type,
   input  logic [tts_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [tts_pkg::TASK_W-1:0]        req_task_id,
   input  logic [tts_pkg::TIME_W-1:0]        req_first_delay,
   input  logic [tts_pkg::TIME_W-1:0]        req_repeat_period,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tts_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [tts_pkg::TASK_W-1:0]        rsp_run_task_id,
   output logic                              rsp_last
);

   localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HIT_W  = tts_pkg::HIT_W;
   localparam int SLOT_W = tts_pkg::SLOT_W;

   // captured transaction
   logic [tts_pkg::OP_W-1:0]   op_ff;
   logic [SLOT_W-1:0]          idx_ff;
   logic [tts_pkg::TASK_W-1:0] id_ff;
   logic [tts_pkg::TIME_W-1:0] dly_ff;
   logic [tts_pkg::TIME_W-1:0] per_ff;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [HIT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [SLOTS-1:0] used_ff;
   logic [SLOTS-1:0] ready_ff;

   tts_pkg::slot_row_type mem [SLOTS];
   tts_pkg::slot_row_type rd_row_ff;
   tts_pkg::slot_row_type wr_row;
   logic                  wr_en;

   logic                        rsp_valid_ff;
   logic [tts_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;
   logic [tts_pkg::TASK_W-1:0]  rsp_id_ff;
   logic                        rsp_last_ff;

   logic [tts_pkg::STATUS_W-1:0] res_status;
   logic [SLOT_W-1:0]            res_slot;
   logic [tts_pkg::TASK_W-1:0]   res_id;
   logic                         res_last;

   logic             emit, finish, load;
   logic             in_range, cur_used, hit, last_hit, any_ready, any_above, is_end;
   logic [SLOTS-1:0] above;
   logic             flag_we, used_val, ready_val;

   assign in_range  = 32'(idx_ff) < 32'(SLOTS);
   assign cur_used  = used_ff[ptr_ff];
   assign hit       = cur_used && (rd_row_ff.pending != '0);
   assign any_ready = |ready_ff;
   assign is_end    = ptr_ff == PTR_W'(SLOTS - 1);

   // ready slots further along the scan, and the hit count against MAX_OUT, decide whether this hit is the final one
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         above[i] = ready_ff[i] && (PTR_W'(i) > ptr_ff);
      end
   end
   assign any_above = |above;
   assign last_hit  = (hit_cnt_ff == HIT_W'(tts_pkg::MAX_OUT - 1)) || !any_above;

   always_comb begin
      emit       = 1'b0;
      finish     = 1'b0;
      res_status = tts_pkg::ST_DONE;
      res_slot   = '0;
      res_id     = '0;
      res_last   = 1'b1;
      wr_en      = 1'b0;
      wr_row     = rd_row_ff;
      flag_we    = 1'b0;
      used_val   = 1'b0;
      ready_val  = 1'b0;
      unique case (op_ff)
         tts_pkg::OP_UPDATE: begin
            emit     = 1'b1;
            finish   = 1'b1;
            res_slot = idx_ff;
            if (in_range && cur_used) begin
               wr_en = 1'b1;
               if (rd_row_ff.delay == '0) begin
                  if (rd_row_ff.pending != tts_pkg::PEND_MAX) begin
                     wr_row.pending = rd_row_ff.pending + 1'b1;
                  end
                  if (rd_row_ff.period != '0) begin
                     wr_row.delay = rd_row_ff.period;
                  end
                  flag_we   = 1'b1;
                  used_val  = 1'b1;
                  ready_val = 1'b1;
               end else begin
                  wr_row.delay = rd_row_ff.delay - 1'b1;
               end
            end
         end
         tts_pkg::OP_ADD: begin
            if (!cur_used) begin
               emit           = 1'b1;
               finish         = 1'b1;
               res_slot       = SLOT_W'(ptr_ff);
               wr_en          = 1'b1;
               wr_row.task_id = id_ff;
               wr_row.delay   = dly_ff;
               wr_row.period  = per_ff;
               wr_row.pending = '0;
               flag_we        = 1'b1;
               used_val       = 1'b1;
            end else if (is_end) begin
               emit       = 1'b1;
               finish     = 1'b1;
               res_status = tts_pkg::ST_FULL;
            end
         end
         tts_pkg::OP_DELETE: begin
            emit     = 1'b1;
            finish   = 1'b1;
            res_slot = idx_ff;
            flag_we  = in_range;
         end
         tts_pkg::OP_DISPATCH: begin
            if (hit) begin
               emit           = 1'b1;
               finish         = last_hit;
               res_status     = tts_pkg::ST_RUN;
               res_slot       = SLOT_W'(ptr_ff);
               res_id         = rd_row_ff.task_id;
               res_last       = last_hit;
               wr_en          = 1'b1;
               wr_row.pending = rd_row_ff.pending - 1'b1;
               flag_we        = 1'b1;
               // one-shot tasks leave the table once they run
               used_val       = rd_row_ff.period != '0;
               ready_val      = (rd_row_ff.period != '0) && (wr_row.pending != '0);
            end else if ((hit_cnt_ff == '0) && !any_ready) begin
               emit       = 1'b1;
               finish     = 1'b1;
               res_status = tts_pkg::ST_NONE;
            end else if (is_end) begin
               finish = 1'b1;
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase
   end

   assign load         = cmd.commit && emit;
   assign sts.emit     = emit;
   assign sts.finish   = finish;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ptr_in     = ptr_ff;
      hit_cnt_in = hit_cnt_ff;
      if (cmd.accept) begin
         hit_cnt_in = '0;
         if ((req_type == tts_pkg::OP_UPDATE) || (req_type == tts_pkg::OP_DELETE)) begin
            ptr_in = PTR_W'(req_slot_index);
         end else begin
            ptr_in = '0;
         end
      end else if (cmd.commit) begin
         if (!finish) begin
            ptr_in = ptr_ff + 1'b1;
         end
         if ((op_ff == tts_pkg::OP_DISPATCH) && hit) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         hit_cnt_ff   <= '0;
         used_ff      <= '0;
         ready_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         hit_cnt_ff <= hit_cnt_in;
         if (cmd.commit && flag_we) begin
            used_ff[ptr_ff]  <= used_val;
            ready_ff[ptr_ff] <= ready_val;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_type;
         idx_ff <= req_slot_index;
         id_ff  <= req_task_id;
         dly_ff <= req_first_delay;
         per_ff <= req_repeat_period;
      end
      if (load) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_id_ff     <= res_id;
         rsp_last_ff   <= res_last;
      end
   end

   // slot rows: one write and one registered read per cycle, both at the scan pointer
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[ptr_ff] <= wr_row;
      end
      rd_row_ff <= mem[ptr_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_run_task_id = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[hw/rtl/tick_task_scheduler_table.sv]
// top level of the tick task scheduler table
//
// a table of SLOTS task slots driven by requests on the req_ channel:
// update ticks one slot, add places a task in the lowest free slot, delete
// frees a slot and dispatch walks the table and reports every slot with
// pending runs, in slot order, one rsp_ transaction per slot (at most eight
// per pass, rsp_last on the final one, status nothing-ready if none).
// update, add and delete give exactly one rsp_ transaction.
// one request is handled at a time; req_ready is low from the accepting edge
// until its final result is loaded into the output register.
// each slot visited takes a row read, then an execute step, on the single
// port of the slot row store; rsp_valid rises once the execute step loads
// the output register. update and delete visit one slot, add the slots up to
// the first free one (every slot when full), dispatch up to every slot.
// a stalled receiver holds the result in the output register; the scan waits
// only when it has a further result and the register is still full, and a
// new request is taken while the last result waits.
// reset empties the table at once (no clearing pass) and drops any result.
module tick_task_scheduler_table #(
   parameter int SLOTS = tts_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tts_pkg::OP_W-1:0]          req_type,
   input  logic [tts_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [tts_pkg::TASK_W-1:0]        req_task_id,
   input  logic [tts_pkg::TIME_W-1:0]        req_first_delay,
   input  logic [tts_pkg::TIME_W-1:0]        req_repeat_period,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tts_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [tts_pkg::TASK_W-1:0]        rsp_run_task_id,
   output logic                              rsp_last
);

   tts_pkg::tts_cmd_type cmd;
   tts_pkg::tts_sts_type sts;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tts_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_slot_index    (req_slot_index),
      .req_task_id       (req_task_id),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_run_task_id   (rsp_run_task_id),
      .rsp_last          (rsp_last)
   );

endmodule

[hw/rtl/tts_checker.sv]
// port-level checks of the tick task scheduler table and their binding
module tts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tts_pkg::STATUS_W-1:0]      rsp_status,
   input logic [tts_pkg::SLOT_W-1:0]        rsp_slot_out,
   input logic [tts_pkg::TASK_W-1:0]        rsp_run_task_id,
   input logic                              rsp_last
);

   // a stalled result transaction holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_out)
         && $stable(rsp_run_task_id) && $stable(rsp_last))
      else $error("result changed while stalled");

   // one request at a time
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // only dispatch results can be followed by more
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != tts_pkg::ST_RUN) |-> rsp_last)
      else $error("non-dispatch result without last");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == tts_pkg::ST_FULL) || (rsp_status == tts_pkg::ST_NONE))
         |-> (rsp_slot_out == '0) && (rsp_run_task_id == '0))
      else $error("table-full or nothing-ready result carries a slot or task");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind tick_task_scheduler_table tts_checker u_tts_checker (.*);
